// ===== sv/ttcw_pkg.sv =====
package ttcw_pkg;

	typedef enum logic [6:0] {
		ST_INIT   = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_EXEC   = 7'b0000100,
		ST_ACCESS = 7'b0001000,
		ST_SCROLL = 7'b0010000,
		ST_CLEAR  = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_BS    = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [1:0] CFG_COLS = 2'd0;
	localparam logic [1:0] CFG_ROWS = 2'd1;
	localparam logic [1:0] CFG_PROT = 2'd2;

	localparam logic [7:0] CHAR_NUL   = 8'd0;
	localparam logic [7:0] CHAR_NL    = 8'd10;
	localparam logic [7:0] CHAR_SPACE = 8'd32;

	localparam logic [7:0] RST_COLS = 8'd80;
	localparam logic [6:0] RST_ROWS = 7'd25;
	localparam logic [5:0] RST_PROT = 6'd0;

endpackage

// ===== sv/ttcw_ram.sv =====
module ttcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/text_terminal_character_writer.sv =====
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in        in         in_valid / in_ready    opcode, char_code, query_col, query_row
// out       out        out_valid / out_ready  cell_written .. scrolled
//
// Put and backspace pass EXEC, ACCESS and DONE with one row-wide read-modify-write
// of the screen RAM, read with one row read; newline and a null byte go from EXEC to
// DONE, or to SCROLL on a newline past the last row. A scroll copies each unprotected
// row from the row below and zeroes the bottom row; a clear fills the unprotected rows
// with spaces up to the active column count, one RAM row per cycle through the single
// read and write port. After reset a clearing pass writes zero to all MAX_ROWS rows,
// one per cycle; in_ready stays low during that pass, configuration writes are taken.
// A finished result waits in the output register while the next transaction runs.
module text_terminal_character_writer #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] char_code,
	input  logic [6:0] query_col,
	input  logic [5:0] query_row,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       cell_written,
	output logic [6:0] written_col,
	output logic [5:0] written_row,
	output logic [7:0] written_char,
	output logic [7:0] read_char,
	output logic [6:0] cursor_col_out,
	output logic [5:0] cursor_row_out,
	output logic       scrolled
);
	import ttcw_pkg::*;

	localparam int CW       = $clog2(MAX_COLS);
	localparam int RW       = $clog2(MAX_ROWS);
	localparam int ACW      = $clog2(MAX_COLS + 1);
	localparam int ARW      = $clog2(MAX_ROWS + 1);
	localparam int ROW_BITS = MAX_COLS * 8;

	typedef logic [MAX_COLS-1:0][7:0] row_t;

	state_t         state_q;
	logic [7:0]     cols_q;
	logic [6:0]     rows_q;
	logic [5:0]     prot_q;
	logic [1:0]     op_q;
	logic [7:0]     ch_q;
	logic [6:0]     qc_q;
	logic [5:0]     qr_q;
	logic [CW-1:0]  cur_col_q;
	logic [RW-1:0]  cur_row_q;
	logic [CW-1:0]  tgt_col_q;
	logic [RW-1:0]  tgt_row_q;
	logic [7:0]     wch_q;
	logic           wr_en_q;
	logic           scroll_q;
	logic           rd_ok_q;
	logic [ARW-1:0] ptr_q;
	logic           pend_s1;
	logic [RW-1:0]  pend_row_s1;
	logic [RW-1:0]  init_q;
	logic           res_written_q;
	logic [7:0]     res_read_q;
	logic           out_valid_q;
	logic           cell_written_q;
	logic [6:0]     written_col_q;
	logic [5:0]     written_row_q;
	logic [7:0]     written_char_q;
	logic [7:0]     read_char_q;
	logic [6:0]     pos_col_q;
	logic [5:0]     pos_row_q;
	logic           scrolled_q;

	logic [ACW-1:0] act_cols;
	logic [ARW-1:0] act_rows;
	logic [ARW-1:0] act_prot;
	logic [RW-1:0]  last_row;
	logic [ACW-1:0] col_inc;
	logic [ARW-1:0] row_inc;
	logic           wrap;
	logic           row_over;
	logic           put_area;
	logic [CW-1:0]  bs_col;
	logic [RW-1:0]  bs_row;
	logic           bs_area;
	logic           q_ok;
	logic [ARW-1:0] ptr_inc;
	logic           scr_more;
	logic           clr_more;

	logic           ram_we;
	logic [RW-1:0]  ram_waddr;
	row_t           ram_wrow;
	logic           ram_re;
	logic [RW-1:0]  ram_raddr;
	logic [ROW_BITS-1:0] ram_rdata;
	row_t           rd_row;
	row_t           put_row;
	row_t           clr_row;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		if (cols_q == '0) begin
			act_cols = ACW'(1);
		end else if (32'(cols_q) > MAX_COLS) begin
			act_cols = ACW'(MAX_COLS);
		end else begin
			act_cols = ACW'(cols_q);
		end
		if (rows_q == '0) begin
			act_rows = ARW'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			act_rows = ARW'(MAX_ROWS);
		end else begin
			act_rows = ARW'(rows_q);
		end
		if (32'(prot_q) >= 32'(act_rows)) begin
			act_prot = act_rows - ARW'(1);
		end else begin
			act_prot = ARW'(prot_q);
		end
	end

	assign last_row = RW'(act_rows - ARW'(1));
	assign col_inc  = ACW'(cur_col_q) + ACW'(1);
	assign row_inc  = ARW'(cur_row_q) + ARW'(1);
	assign wrap     = (col_inc >= act_cols);
	assign row_over = (row_inc >= act_rows);
	assign put_area = (ACW'(cur_col_q) < act_cols) && (ARW'(cur_row_q) < act_rows);
	assign q_ok     = (32'(qc_q) < MAX_COLS) && (32'(qr_q) < MAX_ROWS);
	assign ptr_inc  = ptr_q + ARW'(1);
	assign scr_more = (ptr_inc < act_rows);
	assign clr_more = (ptr_q < act_rows);

	always_comb begin
		bs_col = cur_col_q;
		bs_row = cur_row_q;
		if (cur_col_q != '0) begin
			bs_col = cur_col_q - CW'(1);
		end else if (cur_row_q != '0) begin
			bs_row = cur_row_q - RW'(1);
			bs_col = CW'(act_cols - ACW'(1));
		end
	end
	assign bs_area = (ACW'(bs_col) < act_cols) && (ARW'(bs_row) < act_rows);

	assign rd_row = ram_rdata;

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			put_row[c] = (CW'(c) == tgt_col_q) ? wch_q : rd_row[c];
			clr_row[c] = (c < 32'(act_cols)) ? CHAR_SPACE : rd_row[c];
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pend_row_s1;
		ram_wrow  = rd_row;
		ram_re    = 1'b0;
		ram_raddr = cur_row_q;
		unique case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = init_q;
				ram_wrow  = '0;
			end
			ST_EXEC: begin
				unique case (op_q)
					OP_PUT: begin
						ram_re    = put_area && (ch_q != CHAR_NL) && (ch_q != CHAR_NUL);
						ram_raddr = cur_row_q;
					end
					OP_BS: begin
						ram_re    = bs_area;
						ram_raddr = bs_row;
					end
					OP_READ: begin
						ram_re    = q_ok;
						ram_raddr = RW'(qr_q);
					end
					default: ;
				endcase
			end
			ST_ACCESS: begin
				ram_we    = wr_en_q;
				ram_waddr = tgt_row_q;
				ram_wrow  = put_row;
			end
			ST_SCROLL: begin
				ram_re    = scr_more;
				ram_raddr = RW'(ptr_inc);
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = pend_row_s1;
					ram_wrow  = rd_row;
				end else if (!scr_more) begin
					ram_we    = 1'b1;
					ram_waddr = last_row;
					ram_wrow  = '0;
				end
			end
			ST_CLEAR: begin
				ram_re    = clr_more;
				ram_raddr = RW'(ptr_q);
				ram_we    = pend_s1;
				ram_waddr = pend_row_s1;
				ram_wrow  = clr_row;
			end
			default: ;
		endcase
	end

	ttcw_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(MAX_ROWS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wrow),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= RST_COLS;
			rows_q <= RST_ROWS;
			prot_q <= RST_PROT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_COLS: cols_q <= cfg_data;
				CFG_ROWS: rows_q <= cfg_data[6:0];
				CFG_PROT: prot_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_INIT;
			init_q         <= '0;
			op_q           <= OP_PUT;
			ch_q           <= '0;
			qc_q           <= '0;
			qr_q           <= '0;
			cur_col_q      <= '0;
			cur_row_q      <= '0;
			tgt_col_q      <= '0;
			tgt_row_q      <= '0;
			wch_q          <= '0;
			wr_en_q        <= 1'b0;
			scroll_q       <= 1'b0;
			rd_ok_q        <= 1'b0;
			ptr_q          <= '0;
			pend_s1        <= 1'b0;
			pend_row_s1    <= '0;
			res_written_q  <= 1'b0;
			res_read_q     <= '0;
			out_valid_q    <= 1'b0;
			cell_written_q <= 1'b0;
			written_col_q  <= '0;
			written_row_q  <= '0;
			written_char_q <= '0;
			read_char_q    <= '0;
			pos_col_q      <= '0;
			pos_row_q      <= '0;
			scrolled_q     <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + RW'(1);
					if (init_q == RW'(MAX_ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						ch_q    <= char_code;
						qc_q    <= query_col;
						qr_q    <= query_row;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_written_q <= 1'b0;
					res_read_q    <= '0;
					scroll_q      <= 1'b0;
					wr_en_q       <= 1'b0;
					rd_ok_q       <= 1'b0;
					pend_s1       <= 1'b0;
					ptr_q         <= act_prot;
					unique case (op_q)
						OP_PUT: begin
							if (ch_q == CHAR_NL) begin
								cur_col_q <= '0;
								if (row_over) begin
									cur_row_q <= last_row;
									scroll_q  <= 1'b1;
									state_q   <= ST_SCROLL;
								end else begin
									cur_row_q <= RW'(row_inc);
									state_q   <= ST_DONE;
								end
							end else if (ch_q == CHAR_NUL) begin
								state_q <= ST_DONE;
							end else begin
								tgt_col_q     <= cur_col_q;
								tgt_row_q     <= cur_row_q;
								wch_q         <= ch_q;
								wr_en_q       <= put_area;
								res_written_q <= put_area;
								if (wrap) begin
									cur_col_q <= '0;
									if (row_over) begin
										cur_row_q <= last_row;
										scroll_q  <= 1'b1;
									end else begin
										cur_row_q <= RW'(row_inc);
									end
								end else begin
									cur_col_q <= CW'(col_inc);
								end
								state_q <= ST_ACCESS;
							end
						end
						OP_BS: begin
							cur_col_q     <= bs_col;
							cur_row_q     <= bs_row;
							tgt_col_q     <= bs_col;
							tgt_row_q     <= bs_row;
							wch_q         <= CHAR_SPACE;
							wr_en_q       <= bs_area;
							res_written_q <= bs_area;
							state_q       <= ST_ACCESS;
						end
						OP_CLEAR: begin
							cur_col_q <= '0;
							cur_row_q <= '0;
							state_q   <= ST_CLEAR;
						end
						OP_READ: begin
							rd_ok_q <= q_ok;
							state_q <= ST_ACCESS;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_ACCESS: begin
					if (op_q == OP_READ && rd_ok_q) begin
						res_read_q <= rd_row[CW'(qc_q)];
					end
					if (scroll_q) begin
						state_q <= ST_SCROLL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SCROLL: begin
					if (scr_more) begin
						pend_s1     <= 1'b1;
						pend_row_s1 <= RW'(ptr_q);
						ptr_q       <= ptr_inc;
					end else if (pend_s1) begin
						pend_s1 <= 1'b0;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CLEAR: begin
					if (clr_more) begin
						pend_s1     <= 1'b1;
						pend_row_s1 <= RW'(ptr_q);
						ptr_q       <= ptr_inc;
					end else if (pend_s1) begin
						pend_s1 <= 1'b0;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register frees up
					if (!out_valid_q || out_ready) begin
						out_valid_q    <= 1'b1;
						cell_written_q <= res_written_q;
						written_col_q  <= res_written_q ? 7'(tgt_col_q) : 7'd0;
						written_row_q  <= res_written_q ? 6'(tgt_row_q) : 6'd0;
						written_char_q <= res_written_q ? wch_q : 8'd0;
						read_char_q    <= res_read_q;
						pos_col_q      <= 7'(cur_col_q);
						pos_row_q      <= 6'(cur_row_q);
						scrolled_q     <= scroll_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign cell_written   = cell_written_q;
	assign written_col    = written_col_q;
	assign written_row    = written_row_q;
	assign written_char   = written_char_q;
	assign read_char      = read_char_q;
	assign cursor_col_out = pos_col_q;
	assign cursor_row_out = pos_row_q;
	assign scrolled       = scrolled_q;

endmodule

// ===== bench/text_terminal_character_writer_test.sv =====
`timescale 1ns / 1ps
module text_terminal_character_writer_test;
	import ttcw_pkg::*;

	localparam int MAX_COLS = 128;
	localparam int MAX_ROWS = 64;

	typedef struct {
		logic       cell_written;
		logic [6:0] written_col;
		logic [5:0] written_row;
		logic [7:0] written_char;
		logic [7:0] read_char;
		logic [6:0] col_after;
		logic [5:0] row_after;
		logic       scrolled;
	} term_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = CFG_COLS;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] opcode = OP_PUT;
	logic [7:0] char_code = '0;
	logic [6:0] query_col = '0;
	logic [5:0] query_row = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       cell_written;
	logic [6:0] written_col;
	logic [5:0] written_row;
	logic [7:0] written_char;
	logic [7:0] read_char;
	logic [6:0] cursor_col_out;
	logic [5:0] cursor_row_out;
	logic       scrolled;

	logic [MAX_COLS-1:0][7:0] screen_img [MAX_ROWS];
	logic [7:0] cols_reg;
	logic [6:0] rows_reg;
	logic [5:0] prot_reg;
	int cur_col;
	int cur_row;

	term_result_t pending_results[$];
	int mismatches = 0;
	int burst_left = 0;

	logic [31:0] ready_pattern = '1;
	logic [4:0]  ready_phase = '0;

	text_terminal_character_writer #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ready_pattern[ready_phase];
		ready_phase <= ready_phase + 5'd1;
		if (ready_phase == 5'd31) begin
			ready_pattern <= ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
		end
	end

	function automatic int act_cols();
		if (cols_reg == 0) return 1;
		if (cols_reg > MAX_COLS) return MAX_COLS;
		return int'(cols_reg);
	endfunction

	function automatic int act_rows();
		if (rows_reg == 0) return 1;
		if (rows_reg > MAX_ROWS) return MAX_ROWS;
		return int'(rows_reg);
	endfunction

	function automatic int act_prot();
		int rows;
		rows = act_rows();
		return (int'(prot_reg) >= rows) ? rows - 1 : int'(prot_reg);
	endfunction

	// advance to the next row, scroll the unprotected rows at the bottom
	function automatic logic step_row();
		int rows;
		int r;
		rows = act_rows();
		cur_col = 0;
		cur_row++;
		if (cur_row >= rows) begin
			for (r = act_prot(); r + 1 < rows; r++) screen_img[r] = screen_img[r + 1];
			screen_img[rows - 1] = '0;
			cur_row = rows - 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic term_result_t apply_op(logic [1:0] op, logic [7:0] ch,
			logic [6:0] qc, logic [5:0] qr);
		term_result_t res;
		int cols;
		int rows;
		int r;
		int c;
		res = '{default: '0};
		cols = act_cols();
		rows = act_rows();
		case (op)
			OP_PUT: begin
				if (ch == CHAR_NL) begin
					res.scrolled = step_row();
				end else if (ch != CHAR_NUL) begin
					if (cur_col < cols && cur_row < rows) begin
						screen_img[cur_row][cur_col] = ch;
						res.cell_written = 1'b1;
						res.written_col = cur_col[6:0];
						res.written_row = cur_row[5:0];
						res.written_char = ch;
					end
					cur_col++;
					if (cur_col >= cols) res.scrolled = step_row();
				end
			end
			OP_BS: begin
				if (cur_col > 0) begin
					cur_col--;
				end else if (cur_row > 0) begin
					cur_row--;
					cur_col = cols - 1;
				end
				if (cur_col < cols && cur_row < rows) begin
					screen_img[cur_row][cur_col] = CHAR_SPACE;
					res.cell_written = 1'b1;
					res.written_col = cur_col[6:0];
					res.written_row = cur_row[5:0];
					res.written_char = CHAR_SPACE;
				end
			end
			OP_CLEAR: begin
				for (r = act_prot(); r < rows; r++)
					for (c = 0; c < cols; c++) screen_img[r][c] = CHAR_SPACE;
				cur_col = 0;
				cur_row = 0;
			end
			default: begin
				res.read_char = screen_img[qr][qc];
			end
		endcase
		res.col_after = cur_col[6:0];
		res.row_after = cur_row[5:0];
		return res;
	endfunction

	task automatic check_field(string name, int got, int want);
		if (got != want) begin
			mismatches++;
			$display("%0t: %s got %0d expected %0d", $realtime, name, got, want);
		end
	endtask

	always @(posedge clk) begin : check_results
		term_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				check_field("unexpected result", 1, 0);
			end else begin
				want = pending_results.pop_front();
				check_field("cell_written", cell_written, want.cell_written);
				check_field("written_col", written_col, want.written_col);
				check_field("written_row", written_row, want.written_row);
				check_field("written_char", written_char, want.written_char);
				check_field("read_char", read_char, want.read_char);
				check_field("cursor_col_out", cursor_col_out, want.col_after);
				check_field("cursor_row_out", cursor_row_out, want.row_after);
				check_field("scrolled", scrolled, want.scrolled);
			end
		end
	end

	task automatic send_item(logic [1:0] op, logic [7:0] ch, logic [6:0] qc, logic [5:0] qr);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		in_valid <= 1'b1;
		opcode <= op;
		char_code <= ch;
		query_col <= qc;
		query_row <= qr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(apply_op(op, ch, qc, qr));
		burst_left--;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_COLS: cols_reg = data;
			CFG_ROWS: rows_reg = data[6:0];
			CFG_PROT: prot_reg = data[5:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [7:0] cols, logic [7:0] rows, logic [7:0] prot);
		wait_idle();
		write_reg(CFG_COLS, cols);
		write_reg(CFG_ROWS, rows);
		write_reg(CFG_PROT, prot);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_state();
		send_item(OP_READ, 8'd0, 7'd0, 6'd0);
		send_item(OP_READ, 8'd0, 7'd127, 6'd63);
		send_item(OP_BS, 8'd0, 7'd0, 6'd0);
		send_item(OP_PUT, CHAR_NUL, 7'd0, 6'd0);
		send_item(OP_PUT, 8'h41, 7'd0, 6'd0);
		send_item(OP_PUT, 8'hFF, 7'd0, 6'd0);
		send_item(OP_PUT, CHAR_NL, 7'd0, 6'd0);
		send_item(OP_BS, 8'd0, 7'd0, 6'd0);
		send_item(OP_CLEAR, 8'd0, 7'd0, 6'd0);
		send_item(OP_READ, 8'd0, 7'd80, 6'd0);
	endtask

	task automatic test_register_limits();
		set_config(8'd0, 8'd0, 8'd0);
		send_item(OP_PUT, 8'h78, 7'd0, 6'd0);
		send_item(OP_READ, 8'd0, 7'd0, 6'd0);
		set_config(8'd255, 8'hC0, 8'hFF);
		send_item(OP_PUT, 8'h5A, 7'd0, 6'd0);
		send_item(OP_CLEAR, 8'd0, 7'd0, 6'd0);
		send_item(OP_READ, 8'd0, 7'd127, 6'd63);
		send_item(OP_READ, 8'd0, 7'd0, 6'd0);
	endtask

	task automatic test_cursor_outside();
		set_config(8'd80, 8'd25, 8'd0);
		send_item(OP_PUT, CHAR_NL, 7'd0, 6'd0);
		send_item(OP_PUT, CHAR_NL, 7'd0, 6'd0);
		send_item(OP_PUT, 8'h62, 7'd0, 6'd0);
		set_config(8'd1, 8'd2, 8'd0);
		send_item(OP_PUT, 8'h71, 7'd0, 6'd0);
		send_item(OP_BS, 8'd0, 7'd0, 6'd0);
		send_item(OP_PUT, 8'h77, 7'd0, 6'd0);
	endtask

	task automatic test_protected_clear();
		set_config(8'd4, 8'd3, 8'd7);
		send_item(OP_PUT, 8'h7E, 7'd0, 6'd0);
		send_item(OP_CLEAR, 8'd0, 7'd0, 6'd0);
		send_item(OP_READ, 8'd0, 7'd0, 6'd2);
	endtask

	task automatic test_random_stream();
		logic [7:0] phase_cols [9] = '{80, 8, 128, 1, 16, 255, 0, 20, 3};
		logic [7:0] phase_rows [9] = '{25, 4, 64, 1, 6, 127, 0, 8, 2};
		logic [7:0] phase_prot [9] = '{0, 1, 0, 0, 63, 10, 0, 3, 1};
		int phase_len [9] = '{100, 110, 70, 30, 70, 50, 30, 130, 60};
		int pick;
		logic [1:0] op;
		logic [7:0] ch;
		logic [6:0] qc;
		logic [5:0] qr;
		for (int p = 0; p < 9; p++) begin
			set_config(phase_cols[p], phase_rows[p], phase_prot[p]);
			for (int n = 0; n < phase_len[p]; n++) begin
				pick = $urandom_range(0, 99);
				ch = 8'($urandom_range(0, 255));
				qc = 7'($urandom_range(0, 127));
				qr = 6'($urandom_range(0, 63));
				if (pick < 68) begin
					op = OP_PUT;
					if (pick < 12) ch = CHAR_NL;
					else if (pick < 14) ch = CHAR_NUL;
				end else if (pick < 80) begin
					op = OP_BS;
				end else if (pick < 83) begin
					op = OP_CLEAR;
				end else begin
					op = OP_READ;
					if (pick < 95) begin
						qc = 7'($urandom_range(0, act_cols() - 1));
						qr = 6'($urandom_range(0, act_rows() - 1));
					end
				end
				send_item(op, ch, qc, qr);
			end
		end
	endtask

	initial begin
		for (int r = 0; r < MAX_ROWS; r++) screen_img[r] = '0;
		cols_reg = RST_COLS;
		rows_reg = RST_ROWS;
		prot_reg = RST_PROT;
		cur_col = 0;
		cur_row = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_register_limits();
		test_cursor_outside();
		test_protected_clear();
		test_random_stream();
		wait_idle();
		repeat (80) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
